>>> sv/arp_cache_responder_macros.svh
// Assertion macros for the address cache responder
`ifndef ARP_CACHE_RESPONDER_MACROS_SVH
`define ARP_CACHE_RESPONDER_MACROS_SVH
`ifndef SYNTHESIS
`define ACR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ACR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ACR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ACR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/acr_pkg.sv
// Shared types and constants for the address cache responder
`timescale 1ns / 1ps
`default_nettype none
package acr_pkg;
	localparam int CacheEntries = 16;
	localparam int IdxW = $clog2(CacheEntries);
	localparam int CntW = $clog2(CacheEntries + 1);
	localparam int InW = 1 + 16 * 3 + 48 * 2 + 32 * 3;
	localparam int InBytesW = ((InW + 7) / 8) * 8;
	localparam int OutW = 2 + 1 + 48 * 4 + 32 * 2 + 1;
	localparam int OutBytesW = ((OutW + 7) / 8) * 8;

	localparam logic [15:0] HwEthernet = 16'h0001;
	localparam logic [15:0] ProtoIpv4 = 16'h0800;
	localparam logic [15:0] OpRequest = 16'h0001;
	localparam logic [15:0] OpReply = 16'h0002;
	localparam logic [47:0] MacBcast = '1;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_REPLY = 2'd1,
		ACT_REQUEST = 2'd2,
		ACT_DISCARD = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CMD_RESOLVE = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_REPLY = 2'd2,
		CMD_DISCARD = 2'd3
	} cmd_t;

	localparam logic REG_OWN_MAC = 1'b0;
	localparam logic REG_OWN_IP = 1'b1;

	// classified request handed from front to back
	typedef struct packed {
		cmd_t cmd;
		logic learn_tgt;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [47:0] target_mac;
		logic [31:0] target_ip;
	} job_t;

	typedef struct packed {
		action_t action;
		logic found;
		logic [47:0] found_mac;
		logic [47:0] out_dest_mac;
		logic [47:0] out_sender_mac;
		logic [31:0] out_sender_ip;
		logic [47:0] out_target_mac;
		logic [31:0] out_target_ip;
		logic table_full;
	} result_t;
endpackage
`default_nettype wire

>>> sv/acr_front.sv
// Front end: accept requests, classify them and queue them for the engine
`timescale 1ns / 1ps
`default_nettype none
module acr_front import acr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic func,
	input wire logic [15:0] hw_type,
	input wire logic [15:0] proto_type,
	input wire logic [15:0] arp_oper,
	input wire logic [47:0] sender_mac,
	input wire logic [31:0] sender_ip,
	input wire logic [47:0] target_mac,
	input wire logic [31:0] target_ip,
	input wire logic [31:0] query_ip,
	output logic job_valid,
	input wire logic job_ready,
	output job_t job
);
	// two-entry queue
	job_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	job_t cls;
	logic push, pop;

	always_comb begin
		cls = '0;
		cls.sender_mac = sender_mac;
		cls.sender_ip = sender_ip;
		cls.target_mac = target_mac;
		cls.target_ip = target_ip;
		cls.learn_tgt = (target_mac != MacBcast);
		if (func) begin
			cls.cmd = CMD_RESOLVE;
			cls.target_ip = query_ip;
		end else if (hw_type != HwEthernet || proto_type != ProtoIpv4)
			cls.cmd = CMD_DISCARD;
		else if (arp_oper == OpRequest)
			cls.cmd = CMD_REQUEST;
		else if (arp_oper == OpReply)
			cls.cmd = CMD_REPLY;
		else
			cls.cmd = CMD_DISCARD;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop = job_valid && job_ready;
	assign job = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

>>> sv/acr_engine.sv
// Back end: cache search, learning and result formation
`timescale 1ns / 1ps
`default_nettype none
module acr_engine import acr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [47:0] own_mac,
	input wire logic [31:0] own_ip,
	input wire logic job_valid,
	output logic job_ready,
	input wire job_t job,
	output logic res_valid,
	input wire logic res_ready,
	output result_t res
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_LEARN_S, ST_LEARN_T, ST_LOOK, ST_DONE
	} st_t;

	st_t st_q;
	job_t job_q;
	logic full_q;
	logic [CacheEntries-1:0] valid_q;
	logic [31:0] ip_q [CacheEntries];
	logic [47:0] mac_q [CacheEntries];
	logic [CntW-1:0] fill_q;
	result_t res_q;
	logic res_valid_q;
	logic look_hit_q;
	logic [47:0] look_mac_q;

	logic [31:0] key_ip;
	logic [CacheEntries-1:0] hit_vec;
	logic hit;
	logic [IdxW-1:0] hit_idx;
	logic wr_en;
	logic [IdxW-1:0] wr_idx;
	logic [47:0] wr_mac;
	logic ins;
	result_t res_d;
	logic load_res;

	always_comb begin
		case (st_q)
			ST_LEARN_S: key_ip = job_q.sender_ip;
			default: key_ip = job_q.target_ip;
		endcase
	end

	// parallel tag compare over the cache
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CacheEntries; i++)
			hit_vec[i] = valid_q[i] && (ip_q[i] == key_ip);
		for (int i = CacheEntries - 1; i >= 0; i--)
			if (hit_vec[i]) hit_idx = IdxW'(i);
		hit = |hit_vec;
	end

	always_comb begin
		wr_en = 1'b0;
		ins = 1'b0;
		wr_idx = hit_idx;
		wr_mac = (st_q == ST_LEARN_S) ? job_q.sender_mac : job_q.target_mac;
		if (st_q == ST_LEARN_S || st_q == ST_LEARN_T) begin
			if (hit) wr_en = 1'b1;
			else if (fill_q < CntW'(CacheEntries)) begin
				wr_en = 1'b1;
				ins = 1'b1;
				wr_idx = fill_q[IdxW-1:0];
			end
		end
	end

	// form the result from the registered lookup
	always_comb begin
		res_d = '0;
		case (job_q.cmd)
			CMD_RESOLVE: begin
				if (look_hit_q) begin
					res_d.found = 1'b1;
					res_d.found_mac = look_mac_q;
				end else begin
					res_d.action = ACT_REQUEST;
					res_d.out_dest_mac = MacBcast;
					res_d.out_sender_mac = own_mac;
					res_d.out_sender_ip = own_ip;
					res_d.out_target_ip = job_q.target_ip;
				end
			end
			CMD_REQUEST: begin
				res_d.table_full = full_q;
				if (look_hit_q) begin
					res_d.action = ACT_REPLY;
					res_d.out_dest_mac = job_q.sender_mac;
					res_d.out_sender_mac = own_mac;
					res_d.out_sender_ip = job_q.target_ip;
					res_d.out_target_mac = job_q.sender_mac;
					res_d.out_target_ip = job_q.sender_ip;
				end
			end
			CMD_REPLY: res_d.table_full = full_q;
			default: res_d.action = ACT_DISCARD;
		endcase
	end

	// load the output register only once it is free
	assign load_res = (st_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_q[wr_idx] <= key_ip;
			mac_q[wr_idx] <= wr_mac;
		end
	end

	assign job_ready = (st_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			valid_q <= '0;
			fill_q <= '0;
			full_q <= 1'b0;
			res_valid_q <= 1'b0;
			job_q <= '0;
			res_q <= '0;
			look_hit_q <= 1'b0;
			look_mac_q <= '0;
		end else begin
			if (load_res) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			if (load_res) res_q <= res_d;
			if (ins) begin
				valid_q[wr_idx] <= 1'b1;
				fill_q <= fill_q + 1'b1;
			end
			case (st_q)
				ST_IDLE: if (job_valid) begin
					job_q <= job;
					full_q <= 1'b0;
					case (job.cmd)
						CMD_REQUEST, CMD_REPLY: st_q <= ST_LEARN_S;
						CMD_RESOLVE: st_q <= ST_LOOK;
						default: st_q <= ST_DONE;
					endcase
				end
				ST_LEARN_S: begin
					if (!wr_en) full_q <= 1'b1;
					if (job_q.cmd == CMD_REQUEST) st_q <= ST_LOOK;
					else if (job_q.learn_tgt) st_q <= ST_LEARN_T;
					else st_q <= ST_DONE;
				end
				ST_LEARN_T: begin
					if (!wr_en) full_q <= 1'b1;
					st_q <= ST_DONE;
				end
				ST_LOOK: begin
					look_hit_q <= hit;
					look_mac_q <= mac_q[hit_idx];
					st_q <= ST_DONE;
				end
				ST_DONE: if (load_res) begin
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/arp_cache_responder.sv
// Address cache responder: the engine handles one request at a time, one state per engine step.
// Engine states per request: discard DONE; resolve LOOK, DONE; reply LEARN_S, LEARN_T if the
// target MAC is not broadcast, DONE; request LEARN_S, LOOK, DONE; results wait while the output is held.
// The engine takes a new request only after loading the last result into the output register.
// A two-entry queue decouples intake from the engine; an output register holds results.
// Reset (async, low) empties the cache, the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_cache_responder_macros.svh"
module arp_cache_responder import acr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [47:0] cfg_wdata,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// func, hw_type, proto_type, arp_oper, sender_mac, sender_ip, target_mac,
	// target_ip, query_ip; zero fill
	input wire logic [InBytesW-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// action, found, found_mac, out_dest_mac, out_sender_mac, out_sender_ip,
	// out_target_mac, out_target_ip, table_full; zero fill
	output logic [OutBytesW-1:0] m_axis_tdata
);
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic job_valid, job_ready;
	job_t job;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_MAC: own_mac_q <= cfg_wdata;
				REG_OWN_IP: own_ip_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	acr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.func(s_axis_tdata[0]),
		.hw_type(s_axis_tdata[16:1]),
		.proto_type(s_axis_tdata[32:17]),
		.arp_oper(s_axis_tdata[48:33]),
		.sender_mac(s_axis_tdata[96:49]),
		.sender_ip(s_axis_tdata[128:97]),
		.target_mac(s_axis_tdata[176:129]),
		.target_ip(s_axis_tdata[208:177]),
		.query_ip(s_axis_tdata[240:209]),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	acr_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.own_mac(own_mac_q), .own_ip(own_ip_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[1:0] = res.action;
		m_axis_tdata[2] = res.found;
		m_axis_tdata[50:3] = res.found_mac;
		m_axis_tdata[98:51] = res.out_dest_mac;
		m_axis_tdata[146:99] = res.out_sender_mac;
		m_axis_tdata[178:147] = res.out_sender_ip;
		m_axis_tdata[226:179] = res.out_target_mac;
		m_axis_tdata[258:227] = res.out_target_ip;
		m_axis_tdata[259] = res.table_full;
	end

	`ACR_ASSERT_IMP(a_found_no_send, clk, arst_n, m_axis_tvalid && res.found, res.action == ACT_NONE)
	`ACR_ASSERT_IMP(a_req_bcast, clk, arst_n, m_axis_tvalid && res.action == ACT_REQUEST, res.out_dest_mac == MacBcast)
	`ACR_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire
